// File: sv/mfau_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the mixed fraction arithmetic unit
package mfau_pkg;

  localparam int unsigned FIELD_BITS = 16;
  localparam int unsigned NUM_BITS   = 64;
  localparam int unsigned DEN_BITS   = 48;
  localparam int unsigned WHOLE_BITS = 49;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_LOAD     = 4'd0,
    OP_IMPROPER = 4'd1,
    OP_CROSS    = 4'd2,
    OP_COMBINE  = 4'd3,
    OP_DIV_INIT = 4'd4,
    OP_DIV_STEP = 4'd5,
    OP_QUOT     = 4'd6,
    OP_GCD_INIT = 4'd7,
    OP_GCD_STEP = 4'd8,
    OP_RED_INIT = 4'd9,
    OP_RED_NUM  = 4'd10,
    OP_RED_DEN  = 4'd11,
    OP_IDLE     = 4'd12
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad_den;
    logic div_done;
    logic rem_zero;
    logic gcd_done;
  } status_t;

endpackage

// File: sv/mixed_fraction_arith_unit.sv
`timescale 1ns / 1ps
// top level of the mixed fraction arithmetic unit
// one operation at a time: after the input transfer the result is valid
// straight after the cross products on an error, after the 64-step restoring
// divider for the integer part when it leaves no remainder, and otherwise after
// up to 96 binary gcd steps and two more 64-step divisions that reduce the
// remainder and the denominator; the result holds until its transfer and the
// next input transfer can come once the unit has returned to idle
module mixed_fraction_arith_unit #(
  parameter int unsigned OPERAND_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // mode, a_whole, a_num, a_den, b_whole, b_num, b_den from bit 0 up
  input  logic [103:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // negative, whole_part, frac_num, frac_den, error from bit 0 up
  output logic [151:0] m_axis_tdata_o
);
  mfau_pkg::cmd_t    cmd;
  mfau_pkg::status_t status;
  logic busy, done, err, zf;
  logic neg;
  logic [48:0] whole;
  logic [47:0] rem, den;
  logic in_fire, out_fire;

  assign s_axis_tready_o = !busy;
  assign m_axis_tvalid_o = done;
  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  mfau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_fire_i(out_fire),
    .status_i(status), .cmd_o(cmd), .busy_o(busy), .done_o(done),
    .err_o(err), .zero_frac_o(zf)
  );

  mfau_datapath #(.OperandBits(OPERAND_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .mode_i(s_axis_tdata_i[1:0]),
    .opnd_i(s_axis_tdata_i[97:2]), .status_o(status),
    .neg_o(neg), .whole_o(whole), .rem_o(rem), .den_o(den)
  );

  // error results carry only the flag, padding bits stay zero
  always_comb begin
    m_axis_tdata_o = '0;
    if (err) begin
      m_axis_tdata_o[146] = 1'b1;
    end else begin
      m_axis_tdata_o[0]      = neg;
      m_axis_tdata_o[49:1]   = whole;
      m_axis_tdata_o[97:50]  = zf ? 48'd0 : rem;
      m_axis_tdata_o[145:98] = zf ? 48'd1 : den;
    end
  end
endmodule

// File: sv/mfau_datapath.sv
`timescale 1ns / 1ps
// datapath: improper forms, cross products, serial divider and binary gcd
module mfau_datapath #(
  parameter int unsigned OperandBits = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mfau_pkg::cmd_t                    cmd_i,
  input  logic [1:0]                        mode_i,
  input  logic [6*mfau_pkg::FIELD_BITS-1:0] opnd_i,
  output mfau_pkg::status_t                 status_o,
  output logic                              neg_o,
  output logic [mfau_pkg::WHOLE_BITS-1:0]   whole_o,
  output logic [mfau_pkg::DEN_BITS-1:0]     rem_o,
  output logic [mfau_pkg::DEN_BITS-1:0]     den_o
);
  localparam int unsigned OB = (OperandBits > 16) ? 16 : OperandBits;
  localparam int unsigned NB = mfau_pkg::NUM_BITS;
  localparam int unsigned DB = mfau_pkg::DEN_BITS;
  localparam int unsigned WB = mfau_pkg::WHOLE_BITS;
  localparam int unsigned CB = $clog2(NB + 1);

  logic [15:0] aw_q, an_q, ad_q, bw_q, bn_q, bd_q;
  logic [1:0]  mode_q;
  logic [31:0] ai_q, bi_q;
  logic [NB-1:0] l_q, r_q;
  logic [NB-1:0] num_q, div_q, quo_q;
  logic [NB:0]   rmd_q;
  logic [NB-1:0] dsr_q;
  logic [CB-1:0] cnt_q;
  logic [DB-1:0] gx_q, gy_q, gden_q, grem_q;
  logic [5:0]    gk_q;
  logic [WB-1:0] whole_q;
  logic          neg_q;
  logic [15:0]   mask;

  logic [NB:0]   trial;
  logic [NB:0]   shifted;
  logic [DB-1:0] gval;

  assign mask    = 16'((32'd1 << OB) - 32'd1);
  assign shifted = {rmd_q[NB-1:0], div_q[NB-1]};
  assign trial   = shifted - {1'b0, dsr_q};
  // one side is zero when the loop ends, the other holds the odd part
  assign gval    = (gx_q | gy_q) << gk_q;

  assign status_o.bad_den  = (ad_q == '0) || (bd_q == '0) ||
                             ((mode_q == mfau_pkg::MODE_DIV) && (bi_q == '0));
  assign status_o.div_done = (cnt_q == CB'(NB));
  assign status_o.rem_zero = (rmd_q == '0);
  assign status_o.gcd_done = (gx_q == '0) || (gy_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if ((cmd_i.op == mfau_pkg::OP_DIV_INIT) ||
                 (cmd_i.op == mfau_pkg::OP_RED_INIT) ||
                 (cmd_i.op == mfau_pkg::OP_RED_NUM)) begin
      cnt_q <= '0;
    end else if (cmd_i.op == mfau_pkg::OP_DIV_STEP) begin
      cnt_q <= cnt_q + CB'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      mfau_pkg::OP_LOAD: begin
        mode_q <= mode_i;
        aw_q <= opnd_i[15:0]   & mask;
        an_q <= opnd_i[31:16]  & mask;
        ad_q <= opnd_i[47:32]  & mask;
        bw_q <= opnd_i[63:48]  & mask;
        bn_q <= opnd_i[79:64]  & mask;
        bd_q <= opnd_i[95:80]  & mask;
      end
      mfau_pkg::OP_IMPROPER: begin
        ai_q <= 32'(aw_q) * 32'(ad_q) + 32'(an_q);
        bi_q <= 32'(bw_q) * 32'(bd_q) + 32'(bn_q);
      end
      mfau_pkg::OP_CROSS: begin
        unique case (mode_q)
          mfau_pkg::MODE_MUL: begin
            l_q <= NB'(ai_q) * NB'(bi_q);
            r_q <= NB'(ad_q) * NB'(bd_q);
          end
          mfau_pkg::MODE_DIV: begin
            l_q <= NB'(ai_q) * NB'(bd_q);
            r_q <= NB'(ad_q) * NB'(bi_q);
          end
          default: begin
            l_q <= NB'(ai_q) * NB'(bd_q);
            r_q <= NB'(bi_q) * NB'(ad_q);
          end
        endcase
        gden_q <= DB'(ad_q) * DB'(bd_q);
      end
      mfau_pkg::OP_COMBINE: begin
        neg_q <= 1'b0;
        unique case (mode_q)
          mfau_pkg::MODE_ADD: num_q <= l_q + r_q;
          mfau_pkg::MODE_SUB: begin
            if (l_q >= r_q) begin
              num_q <= l_q - r_q;
            end else begin
              num_q <= r_q - l_q;
              neg_q <= 1'b1;
            end
          end
          mfau_pkg::MODE_MUL: num_q <= l_q;
          default: begin
            num_q  <= l_q;
            gden_q <= r_q[DB-1:0];
          end
        endcase
      end
      mfau_pkg::OP_DIV_INIT: begin
        if (num_q == '0) neg_q <= 1'b0;
        div_q <= num_q;
        dsr_q <= NB'(gden_q);
        rmd_q <= '0;
        quo_q <= '0;
      end
      mfau_pkg::OP_DIV_STEP: begin
        div_q <= div_q << 1;
        if (!trial[NB]) begin
          rmd_q <= trial;
          quo_q <= {quo_q[NB-2:0], 1'b1};
        end else begin
          rmd_q <= shifted;
          quo_q <= {quo_q[NB-2:0], 1'b0};
        end
      end
      mfau_pkg::OP_QUOT: begin
        // integer part saturates at all ones
        whole_q <= (quo_q[NB-1:WB] != '0) ? '1 : quo_q[WB-1:0];
        grem_q  <= rmd_q[DB-1:0];
      end
      mfau_pkg::OP_GCD_INIT: begin
        gx_q <= gden_q;
        gy_q <= grem_q;
        gk_q <= '0;
      end
      mfau_pkg::OP_GCD_STEP: begin
        if (!gx_q[0] && !gy_q[0]) begin
          gx_q <= gx_q >> 1;
          gy_q <= gy_q >> 1;
          gk_q <= gk_q + 6'd1;
        end else if (!gx_q[0]) begin
          gx_q <= gx_q >> 1;
        end else if (!gy_q[0]) begin
          gy_q <= gy_q >> 1;
        end else if (gx_q >= gy_q) begin
          gx_q <= (gx_q - gy_q) >> 1;
        end else begin
          gy_q <= (gy_q - gx_q) >> 1;
        end
      end
      mfau_pkg::OP_RED_INIT: begin
        div_q <= NB'(grem_q);
        dsr_q <= NB'(gval);
        rmd_q <= '0;
        quo_q <= '0;
      end
      mfau_pkg::OP_RED_NUM: begin
        grem_q <= quo_q[DB-1:0];
        div_q  <= NB'(gden_q);
        rmd_q  <= '0;
        quo_q  <= '0;
      end
      mfau_pkg::OP_RED_DEN: gden_q <= quo_q[DB-1:0];
      default: ;
    endcase
  end

  assign neg_o   = neg_q;
  assign whole_o = whole_q;
  assign rem_o   = grem_q;
  assign den_o   = gden_q;
endmodule

// File: sv/mfau_ctrl.sv
`timescale 1ns / 1ps
// controller state machine sequencing the datapath
module mfau_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic              out_fire_i,
  input  mfau_pkg::status_t status_i,
  output mfau_pkg::cmd_t    cmd_o,
  output logic              busy_o,
  output logic              done_o,
  output logic              err_o,
  output logic              zero_frac_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_IMP   = 9'b000000010,
    S_CROSS = 9'b000000100,
    S_COMB  = 9'b000001000,
    S_DINIT = 9'b000010000,
    S_DSTEP = 9'b000100000,
    S_GINIT = 9'b001000000,
    S_GSTEP = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  // which division the serial divider is running
  typedef enum logic [2:0] {
    PH_WHOLE = 3'b001,
    PH_NUM   = 3'b010,
    PH_DEN   = 3'b100
  } phase_e;

  state_e state_q, state_d;
  phase_e ph_q, ph_d;
  logic   err_q, err_d, zf_q, zf_d;

  always_comb begin
    state_d = state_q;
    ph_d    = ph_q;
    err_d   = err_q;
    zf_d    = zf_q;
    cmd_o.op = mfau_pkg::OP_IDLE;
    unique case (state_q)
      S_IDLE: if (in_fire_i) begin
        cmd_o.op = mfau_pkg::OP_LOAD;
        state_d  = S_IMP;
      end
      S_IMP: begin
        cmd_o.op = mfau_pkg::OP_IMPROPER;
        state_d  = S_CROSS;
      end
      S_CROSS: begin
        cmd_o.op = mfau_pkg::OP_CROSS;
        err_d    = status_i.bad_den;
        state_d  = status_i.bad_den ? S_DONE : S_COMB;
      end
      S_COMB: begin
        cmd_o.op = mfau_pkg::OP_COMBINE;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = mfau_pkg::OP_DIV_INIT;
        ph_d     = PH_WHOLE;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        if (status_i.div_done) begin
          unique case (ph_q)
            PH_WHOLE: begin
              cmd_o.op = mfau_pkg::OP_QUOT;
              zf_d     = status_i.rem_zero;
              state_d  = status_i.rem_zero ? S_DONE : S_GINIT;
            end
            PH_NUM: begin
              cmd_o.op = mfau_pkg::OP_RED_NUM;
              ph_d     = PH_DEN;
            end
            PH_DEN: begin
              cmd_o.op = mfau_pkg::OP_RED_DEN;
              state_d  = S_DONE;
            end
            default: state_d = S_IDLE;
          endcase
        end else begin
          cmd_o.op = mfau_pkg::OP_DIV_STEP;
        end
      end
      S_GINIT: begin
        cmd_o.op = mfau_pkg::OP_GCD_INIT;
        state_d  = S_GSTEP;
      end
      S_GSTEP: begin
        if (status_i.gcd_done) begin
          cmd_o.op = mfau_pkg::OP_RED_INIT;
          ph_d     = PH_NUM;
          state_d  = S_DSTEP;
        end else begin
          cmd_o.op = mfau_pkg::OP_GCD_STEP;
        end
      end
      S_DONE: if (out_fire_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q    <= PH_WHOLE;
      err_q   <= 1'b0;
      zf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ph_q    <= ph_d;
      err_q   <= err_d;
      zf_q    <= zf_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign done_o      = (state_q == S_DONE);
  assign err_o       = err_q;
  assign zero_frac_o = zf_q;
endmodule

// File: sv/mfau_checker.sv
`timescale 1ns / 1ps
// port checker for the mixed fraction arithmetic unit
module mfau_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [151:0] m_axis_tdata_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("accepting while result pending");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[146] |-> m_axis_tdata_o[145:0] == '0)
    else $error("error result not zeroed");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready after transfer");
endmodule

bind mixed_fraction_arith_unit mfau_checker u_chk (.*);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// testbench for the mixed fraction arithmetic unit: directed and random operations
module tb_top;

  typedef struct packed {
    logic        err;
    logic [47:0] den;
    logic [47:0] num;
    logic [48:0] whole;
    logic        neg;
  } frac_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [103:0] s_axis_tdata_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [151:0] m_axis_tdata_o;

  frac_result_t pending_results[$];
  int unsigned  mismatches;
  int unsigned  unexpected;

  mixed_fraction_arith_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact sign-magnitude mixed result of one operation
  function automatic frac_result_t mixed_result(mfau_pkg::mode_e op, logic [15:0] aw,
                                                logic [15:0] an, logic [15:0] ad,
                                                logic [15:0] bw, logic [15:0] bn,
                                                logic [15:0] bd);
    frac_result_t r;
    logic [63:0] ai, bi, num, den, wh, rem, g, l, rr;
    logic neg;
    r = '0;
    neg = 1'b0;
    if (ad == 0 || bd == 0) begin
      r.err = 1'b1;
      return r;
    end
    ai = 64'(aw) * ad + an;
    bi = 64'(bw) * bd + bn;
    den = 64'(ad) * bd;
    case (op)
      mfau_pkg::MODE_ADD: num = ai * bd + bi * ad;
      mfau_pkg::MODE_SUB: begin
        l = ai * bd;
        rr = bi * ad;
        if (l >= rr) num = l - rr;
        else begin
          num = rr - l;
          neg = 1'b1;
        end
      end
      mfau_pkg::MODE_MUL: num = ai * bi;
      default: begin
        if (bi == 0) begin
          r.err = 1'b1;
          return r;
        end
        num = ai * bd;
        den = 64'(ad) * bi;
      end
    endcase
    wh = num / den;
    rem = num % den;
    if (rem == 0) den = 1;
    else begin
      g = euclid(den, rem);
      rem = rem / g;
      den = den / g;
    end
    if (num == 0) neg = 1'b0;
    if (wh > 64'h1_FFFF_FFFF_FFFF) wh = 64'h1_FFFF_FFFF_FFFF;
    r.neg = neg;
    r.whole = wh[48:0];
    r.num = rem[47:0];
    r.den = den[47:0];
    return r;
  endfunction

  // send one operation, predicting its result at the transfer
  task automatic send_op(mfau_pkg::mode_e op, logic [15:0] aw, logic [15:0] an,
                         logic [15:0] ad, logic [15:0] bw, logic [15:0] bn,
                         logic [15:0] bd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'd0, bd, bn, bw, ad, an, aw, op};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pending_results.push_back(mixed_result(op, aw, an, ad, bw, bn, bd));
  endtask

  // receiver with random stalls, compares against the oldest prediction
  initial begin
    frac_result_t got, want;
    int stall;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got = frac_result_t'(m_axis_tdata_o[146:0]);
      if (pending_results.size() == 0) begin
        unexpected++;
        $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: neg %b/%b whole %h/%h num %h/%h den %h/%h err %b/%b (exp/act)",
                     want.neg, got.neg, want.whole, got.whole, want.num, got.num,
                     want.den, got.den, want.err, got.err);
        end
      end
    end
  end

  task automatic test_extremes();
    send_op(mfau_pkg::MODE_ADD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_op(mfau_pkg::MODE_SUB, 16'd0, 16'd0, 16'd1, 16'd0, 16'd0, 16'd1);
    send_op(mfau_pkg::MODE_MUL, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF);
    send_op(mfau_pkg::MODE_MUL, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1);
    send_op(mfau_pkg::MODE_MUL, 16'hFFFF, 16'h7FFF, 16'd2, 16'hFFFF, 16'h7FFF, 16'd2);
    send_op(mfau_pkg::MODE_DIV, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF);
    send_op(mfau_pkg::MODE_DIV, 16'd1, 16'd1, 16'd3, 16'd2, 16'd3, 16'd7);
    send_op(mfau_pkg::MODE_ADD, 16'd1, 16'd1, 16'd2, 16'd1, 16'd1, 16'd3);
  endtask

  task automatic test_special_cases();
    // zero denominator on a
    send_op(mfau_pkg::MODE_ADD, 16'd5, 16'd1, 16'd0, 16'd1, 16'd1, 16'd2);
    // zero denominator on b
    send_op(mfau_pkg::MODE_MUL, 16'd5, 16'd1, 16'd3, 16'd1, 16'd1, 16'd0);
    // division by zero
    send_op(mfau_pkg::MODE_DIV, 16'd3, 16'd1, 16'd2, 16'd0, 16'd0, 16'd9);
    // zero result
    send_op(mfau_pkg::MODE_SUB, 16'd2, 16'd1, 16'd3, 16'd2, 16'd1, 16'd3);
    // zero times something
    send_op(mfau_pkg::MODE_MUL, 16'd0, 16'd0, 16'd5, 16'd7, 16'd1, 16'd2);
    // below zero
    send_op(mfau_pkg::MODE_SUB, 16'd1, 16'd1, 16'd4, 16'd3, 16'd2, 16'd5);
    send_op(mfau_pkg::MODE_SUB, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    // improper fraction input
    send_op(mfau_pkg::MODE_ADD, 16'd0, 16'd6, 16'd4, 16'd0, 16'd9, 16'd6);
  endtask

  task automatic test_random(int count);
    logic [15:0] f[6];
    mfau_pkg::mode_e op;
    for (int i = 0; i < count; i++) begin
      op = mfau_pkg::mode_e'($urandom_range(0, 3));
      for (int k = 0; k < 6; k++) begin
        case ($urandom_range(0, 5))
          0: f[k] = 16'($urandom_range(0, 3));
          1: f[k] = 16'hFFFF - 16'($urandom_range(0, 3));
          2: f[k] = 16'($urandom_range(0, 40));
          default: f[k] = 16'($urandom);
        endcase
      end
      send_op(op, f[0], f[1], f[2], f[3], f[4], f[5]);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    mismatches = 0;
    unexpected = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_random(1400);
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && unexpected == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  // about 1420 items with their computation plus both stalls, several times over
  initial begin
    #30_000_000;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
